// ===== hdl/ipk_pkg.sv =====
// Package for the iambic paddle keyer: phase codes, mode and register codes, shared types.
package ipk_pkg;

  // Keyer phase of the iambic machine
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CHK_DIT = 3'd1,
    PH_CHK_DAH = 3'd2,
    PH_PREP    = 3'd3,
    PH_KEYED   = 3'd4,
    PH_GAP     = 3'd5
  } ph_t;

  // Key mode codes; any other code runs as iambic A
  localparam logic [1:0] MODE_A        = 2'd0;
  localparam logic [1:0] MODE_B        = 2'd1;
  localparam logic [1:0] MODE_STRAIGHT = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_DOT  = 3'd1;
  localparam logic [2:0] REG_DASH = 3'd2;
  localparam logic [2:0] REG_GAP  = 3'd3;
  localparam logic [2:0] REG_PTT  = 3'd4;

  // Width of the length registers
  localparam int LEN_BITS = 12;

  // Register reset values
  localparam logic [1:0]          MODE_RST = MODE_A;
  localparam logic [LEN_BITS-1:0] DOT_RST  = 12'd60;
  localparam logic [LEN_BITS-1:0] DASH_RST = 12'd180;
  localparam logic [LEN_BITS-1:0] GAP_RST  = 12'd54;
  localparam logic                PTT_RST  = 1'b1;

  // Configuration seen by the keyer machine
  typedef struct packed {
    logic [1:0]          key_mode_sel;
    logic [LEN_BITS-1:0] dot_ticks;
    logic [LEN_BITS-1:0] dash_ticks;
    logic [LEN_BITS-1:0] gap_ticks;
    logic                ptt_on;
  } ipk_cfg_t;

  // One result item
  typedef struct packed {
    logic key_down;
    logic ptt_active;
    logic busy_res;
  } ipk_res_t;

endpackage

// ===== hdl/ipk_in_if.sv =====
// Input channel: one millisecond tick with the two paddle levels.
interface ipk_in_if;
  logic valid;
  logic ready;
  logic dit_pressed;
  logic dah_pressed;

  modport source (output valid, output dit_pressed, output dah_pressed, input ready);
  modport sink   (input valid, input dit_pressed, input dah_pressed, output ready);
endinterface

// ===== hdl/ipk_out_if.sv =====
// Output channel: key line, push-to-talk line and busy flag for one tick.
interface ipk_out_if;
  logic valid;
  logic ready;
  logic key_down;
  logic ptt_active;
  logic busy_res;

  modport source (output valid, output key_down, output ptt_active, output busy_res,
                  input ready);
  modport sink   (input valid, input key_down, input ptt_active, input busy_res,
                  output ready);
endinterface

// ===== hdl/ipk_fsm.sv =====
// Keyer state machine: state registers and the per-tick next-state logic.
module ipk_fsm #(
  parameter int TIME_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              dit,
  input  logic              dah,
  input  ipk_pkg::ipk_cfg_t cfg,
  output ipk_pkg::ipk_res_t res
);

  localparam int WIDE = (TIME_BITS > ipk_pkg::LEN_BITS) ? TIME_BITS : ipk_pkg::LEN_BITS;
  localparam logic [WIDE-1:0] TIME_MAX = WIDE'((64'd1 << TIME_BITS) - 64'd1);

  ipk_pkg::ph_t         phase, phase_next;
  logic                 dit_latch, dit_latch_next;
  logic                 dah_latch, dah_latch_next;
  logic                 dit_in_progress, dit_in_progress_next;
  logic [TIME_BITS-1:0] countdown, countdown_next;
  logic                 key_reg, key_reg_next;
  logic                 ptt_reg, ptt_reg_next;
  logic                 busy;

  // Saturate a length to the counter width
  function automatic logic [TIME_BITS-1:0] fit_time(input logic [ipk_pkg::LEN_BITS-1:0] v);
    logic [WIDE-1:0] vw;
    vw = WIDE'(v);
    fit_time = (vw > TIME_MAX) ? TIME_BITS'(TIME_MAX) : TIME_BITS'(vw);
  endfunction

  // Next state for one tick
  always_comb begin
    phase_next           = phase;
    dit_latch_next       = dit_latch;
    dah_latch_next       = dah_latch;
    dit_in_progress_next = dit_in_progress;
    countdown_next       = countdown;
    key_reg_next         = key_reg;
    ptt_reg_next         = ptt_reg;
    busy                 = 1'b0;
    if (cfg.key_mode_sel == ipk_pkg::MODE_STRAIGHT) begin
      busy         = dit | dah;
      key_reg_next = dit | dah;
      ptt_reg_next = dit | dah;
    end else begin
      unique case (phase)
        ipk_pkg::PH_IDLE: begin
          if (dit || dah || dit_latch || dah_latch) begin
            dit_latch_next = dit_latch | dit;
            dah_latch_next = dah_latch | dah;
            phase_next     = ipk_pkg::PH_CHK_DIT;
            busy           = 1'b1;
          end
        end
        ipk_pkg::PH_CHK_DIT: begin
          if (dit_latch) begin
            dit_in_progress_next = 1'b1;
            countdown_next       = fit_time(cfg.dot_ticks);
            phase_next           = ipk_pkg::PH_PREP;
            busy                 = 1'b1;
          end else if (dah_latch) begin
            countdown_next = fit_time(cfg.dash_ticks);
            phase_next     = ipk_pkg::PH_PREP;
            busy           = 1'b1;
          end else begin
            phase_next = ipk_pkg::PH_IDLE;
          end
        end
        ipk_pkg::PH_CHK_DAH: begin
          if (dah_latch) begin
            countdown_next = fit_time(cfg.dash_ticks);
            phase_next     = ipk_pkg::PH_PREP;
            busy           = 1'b1;
          end else begin
            phase_next = ipk_pkg::PH_IDLE;
          end
        end
        ipk_pkg::PH_PREP: begin
          if (cfg.ptt_on) begin
            ptt_reg_next = 1'b1;
          end
          key_reg_next   = 1'b1;
          dit_latch_next = 1'b0;
          dah_latch_next = 1'b0;
          phase_next     = ipk_pkg::PH_KEYED;
          busy           = 1'b1;
        end
        ipk_pkg::PH_KEYED: begin
          busy = 1'b1;
          if (countdown == '0) begin
            ptt_reg_next   = 1'b0;
            key_reg_next   = 1'b0;
            countdown_next = fit_time(cfg.gap_ticks);
            phase_next     = ipk_pkg::PH_GAP;
          end else begin
            countdown_next = countdown - 1'b1;
            // iambic B latches while the key is down
            if (cfg.key_mode_sel == ipk_pkg::MODE_B) begin
              dit_latch_next = dit_latch | dit;
              dah_latch_next = dah_latch | dah;
            end
          end
        end
        ipk_pkg::PH_GAP: begin
          dit_latch_next = dit_latch | dit;
          dah_latch_next = dah_latch | dah;
          if (countdown == '0) begin
            if (dit_in_progress) begin
              dit_latch_next       = 1'b0;
              dit_in_progress_next = 1'b0;
              phase_next           = ipk_pkg::PH_CHK_DAH;
              busy                 = 1'b1;
            end else begin
              dah_latch_next = 1'b0;
              phase_next     = ipk_pkg::PH_IDLE;
            end
          end else begin
            countdown_next = countdown - 1'b1;
            busy           = 1'b1;
          end
        end
        default: begin
          phase_next = ipk_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res.key_down   = key_reg_next;
    res.ptt_active = ptt_reg_next;
    res.busy_res   = busy;
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ipk_pkg::PH_IDLE;
      dit_latch       <= 1'b0;
      dah_latch       <= 1'b0;
      dit_in_progress <= 1'b0;
      countdown       <= '0;
      key_reg         <= 1'b0;
      ptt_reg         <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      dit_latch       <= dit_latch_next;
      dah_latch       <= dah_latch_next;
      dit_in_progress <= dit_in_progress_next;
      countdown       <= countdown_next;
      key_reg         <= key_reg_next;
      ptt_reg         <= ptt_reg_next;
    end
  end

endmodule

// ===== hdl/iambic_paddle_keyer_core.sv =====
// Iambic paddle keyer core: register port, keyer machine and two-entry result queue.
//
// Each input item is one millisecond tick with the dit and dah paddle levels; the block
// returns one result per tick (key line, push-to-talk line, busy flag). A tick is worked
// out combinationally by the keyer next-state logic and its result is registered into a
// two-entry result queue as the tick is taken, so one item is taken every clock; the input
// side stalls only when both queue entries wait on the output. Modes: iambic A, iambic B
// (paddles also latched during key-down) and straight key. A length L is counted down over
// L+1 ticks. Registers sit at byte addresses 0, 4, 8, 12 and 16 (mode, dit, dah, gap, ptt
// enable); the user is to write them only while the block idles, which it does not enforce.
module iambic_paddle_keyer_core #(
  parameter int TIME_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  ipk_in_if.sink      in_ch,
  ipk_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ipk_pkg::ipk_cfg_t cfg;
  ipk_pkg::ipk_res_t res;
  ipk_pkg::ipk_res_t slot0, slot1;
  logic [1:0]        cnt;
  logic              push, pop, cfg_wr;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_mode_sel <= ipk_pkg::MODE_RST;
      cfg.dot_ticks    <= ipk_pkg::DOT_RST;
      cfg.dash_ticks   <= ipk_pkg::DASH_RST;
      cfg.gap_ticks    <= ipk_pkg::GAP_RST;
      cfg.ptt_on       <= ipk_pkg::PTT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        ipk_pkg::REG_MODE: cfg.key_mode_sel <= pwdata[1:0];
        ipk_pkg::REG_DOT:  cfg.dot_ticks    <= pwdata[ipk_pkg::LEN_BITS-1:0];
        ipk_pkg::REG_DASH: cfg.dash_ticks   <= pwdata[ipk_pkg::LEN_BITS-1:0];
        ipk_pkg::REG_GAP:  cfg.gap_ticks    <= pwdata[ipk_pkg::LEN_BITS-1:0];
        ipk_pkg::REG_PTT:  cfg.ptt_on       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      ipk_pkg::REG_MODE: prdata = {30'd0, cfg.key_mode_sel};
      ipk_pkg::REG_DOT:  prdata = {20'd0, cfg.dot_ticks};
      ipk_pkg::REG_DASH: prdata = {20'd0, cfg.dash_ticks};
      ipk_pkg::REG_GAP:  prdata = {20'd0, cfg.gap_ticks};
      ipk_pkg::REG_PTT:  prdata = {31'd0, cfg.ptt_on};
      default:           prdata = 32'd0;
    endcase
  end

  // Keyer machine, stepped once per accepted tick
  ipk_fsm #(.TIME_BITS(TIME_BITS)) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (push),
    .dit  (in_ch.dit_pressed),
    .dah  (in_ch.dah_pressed),
    .cfg  (cfg),
    .res  (res)
  );

  // Handshakes
  assign in_ch.ready = (cnt != 2'd2);
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = out_ch.valid & out_ch.ready;

  // Two-entry result queue, head in slot0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && pop) begin
      if (cnt == 2'd1) begin
        slot0 <= res;
      end else begin
        slot0 <= slot1;
        slot1 <= res;
      end
    end
  end

  assign out_ch.valid      = (cnt != 2'd0);
  assign out_ch.key_down   = slot0.key_down;
  assign out_ch.ptt_active = slot0.ptt_active;
  assign out_ch.busy_res   = slot0.busy_res;

  // Queue never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");

  // A full queue that drains without a new tick drops to one entry
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop && !push) |=> (cnt == 2'd1))
    else $error("result queue drain miscounted");

  // Straight mode keys from the paddles of the same tick
  a_straight: assert property (@(posedge clk) disable iff (rst)
    (push && cfg.key_mode_sel == ipk_pkg::MODE_STRAIGHT) |->
      (res.key_down == (in_ch.dit_pressed | in_ch.dah_pressed) &&
       res.busy_res == res.key_down))
    else $error("straight mode key line mismatch");

endmodule

// ===== tb/iambic_paddle_keyer_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the iambic paddle keyer core: paddle ticks in, key/ptt/busy lines checked.
module iambic_paddle_keyer_core_tb;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 10;
  localparam int RESULT_LAT  = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;

  typedef logic [ipk_pkg::LEN_BITS-1:0] len_t;

  // Mode code three runs as iambic A
  localparam logic [1:0] MODE_RSVD = 2'd3;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ipk_in_if  in_if ();
  ipk_out_if out_if ();

  iambic_paddle_keyer_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Keyer model state and its copy of the registers
  ipk_pkg::ipk_cfg_t kcfg;
  ipk_pkg::ph_t      kph;
  logic              lat_dit;
  logic              lat_dah;
  logic              dit_run;
  logic              key_q;
  logic              ptt_q;
  len_t              cnt;

  ipk_pkg::ipk_res_t line_q[$];
  int unsigned       err_cnt = 0;
  bit                send_idle = 1'b1;
  bit                sink_idle = 1'b1;
  bit                hold_req  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  // Element length: mostly short, sometimes zero or longer
  function automatic len_t pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 16) return len_t'($urandom_range(1, 6));
    return len_t'($urandom_range(7, 40));
  endfunction

  // Advance the keyer model by one tick and return the lines it drives
  task automatic keyer_step(input logic dit, input logic dah,
                            output ipk_pkg::ipk_res_t res);
    logic busy;
    busy = 1'b0;
    if (kcfg.key_mode_sel == ipk_pkg::MODE_STRAIGHT) begin
      busy  = dit | dah;
      key_q = busy;
      ptt_q = busy;
    end else begin
      case (kph)
        ipk_pkg::PH_IDLE: begin
          if (dit || dah || lat_dit || lat_dah) begin
            lat_dit = lat_dit | dit;
            lat_dah = lat_dah | dah;
            kph     = ipk_pkg::PH_CHK_DIT;
            busy    = 1'b1;
          end
        end
        ipk_pkg::PH_CHK_DIT: begin
          // fall through to the dah check when no dit is latched
          if (lat_dit) begin
            dit_run = 1'b1;
            cnt     = kcfg.dot_ticks;
            kph     = ipk_pkg::PH_PREP;
            busy    = 1'b1;
          end else if (lat_dah) begin
            cnt  = kcfg.dash_ticks;
            kph  = ipk_pkg::PH_PREP;
            busy = 1'b1;
          end else kph = ipk_pkg::PH_IDLE;
        end
        ipk_pkg::PH_CHK_DAH: begin
          if (lat_dah) begin
            cnt  = kcfg.dash_ticks;
            kph  = ipk_pkg::PH_PREP;
            busy = 1'b1;
          end else kph = ipk_pkg::PH_IDLE;
        end
        ipk_pkg::PH_PREP: begin
          if (kcfg.ptt_on) ptt_q = 1'b1;
          key_q   = 1'b1;
          lat_dit = 1'b0;
          lat_dah = 1'b0;
          kph     = ipk_pkg::PH_KEYED;
          busy    = 1'b1;
        end
        ipk_pkg::PH_KEYED: begin
          busy = 1'b1;
          if (cnt == '0) begin
            ptt_q = 1'b0;
            key_q = 1'b0;
            cnt   = kcfg.gap_ticks;
            kph   = ipk_pkg::PH_GAP;
          end else begin
            cnt = cnt - 1'b1;
            // iambic B latches during key-down too
            if (kcfg.key_mode_sel == ipk_pkg::MODE_B) begin
              lat_dit = lat_dit | dit;
              lat_dah = lat_dah | dah;
            end
          end
        end
        ipk_pkg::PH_GAP: begin
          lat_dit = lat_dit | dit;
          lat_dah = lat_dah | dah;
          if (cnt == '0) begin
            if (dit_run) begin
              lat_dit = 1'b0;
              dit_run = 1'b0;
              kph     = ipk_pkg::PH_CHK_DAH;
              busy    = 1'b1;
            end else begin
              lat_dah = 1'b0;
              kph     = ipk_pkg::PH_IDLE;
            end
          end else begin
            cnt  = cnt - 1'b1;
            busy = 1'b1;
          end
        end
        default: kph = ipk_pkg::PH_IDLE;
      endcase
    end
    res = '{key_down: key_q, ptt_active: ptt_q, busy_res: busy};
  endtask

  // Offer one tick, hold it until taken, then queue its expected lines
  task automatic send_tick(input logic dit, input logic dah);
    int unsigned       gap;
    ipk_pkg::ipk_res_t want;
    gap = (send_idle && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.dit_pressed <= dit;
    in_if.dah_pressed <= dah;
    do @(posedge clk); while (!in_if.ready);
    keyer_step(dit, dah, want);
    line_q.push_back(want);
  endtask

  // Send released paddles until the keyer settles back to idle
  task automatic drain_keyer();
    while (kcfg.key_mode_sel != ipk_pkg::MODE_STRAIGHT &&
           (kph != ipk_pkg::PH_IDLE || lat_dit || lat_dah))
      send_tick(1'b0, 1'b0);
  endtask

  // Drop valid and wait out every pending result
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (RESULT_LAT) @(posedge clk);
  endtask

  // Register write: setup phase, access phase until pready, then an idle phase
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      ipk_pkg::REG_MODE: kcfg.key_mode_sel = val[1:0];
      ipk_pkg::REG_DOT:  kcfg.dot_ticks    = val[ipk_pkg::LEN_BITS-1:0];
      ipk_pkg::REG_DASH: kcfg.dash_ticks   = val[ipk_pkg::LEN_BITS-1:0];
      ipk_pkg::REG_GAP:  kcfg.gap_ticks    = val[ipk_pkg::LEN_BITS-1:0];
      ipk_pkg::REG_PTT:  kcfg.ptt_on       = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] mode, input len_t dot,
                            input len_t dash, input len_t gap, input logic ptt);
    drain_keyer();
    wait_idle();
    reg_write(ipk_pkg::REG_MODE, 32'(mode));
    reg_write(ipk_pkg::REG_DOT, 32'(dot));
    reg_write(ipk_pkg::REG_DASH, 32'(dash));
    reg_write(ipk_pkg::REG_GAP, 32'(gap));
    reg_write(ipk_pkg::REG_PTT, 32'(ptt));
  endtask

  // Paddle activity: mostly held patterns, the rest single-tick noise
  task automatic run_paddles(input int unsigned n);
    int unsigned sent;
    int unsigned run;
    logic [1:0]  pat;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) != 0) begin
        pat = 2'($urandom_range(0, 3));
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      end else begin
        pat = 2'($urandom_range(0, 3));
        run = 1;
      end
      repeat (run) send_tick(pat[0], pat[1]);
      sent += run;
    end
  endtask

  // Taps, squeezes and early latching, starting from the reset lengths
  task automatic test_directed();
    send_tick(1'b1, 1'b0);
    set_config(ipk_pkg::MODE_A, 12'd1, 12'd3, 12'd1, 1'b1);
    send_tick(1'b1, 1'b0);
    drain_keyer();
    send_tick(1'b0, 1'b1);
    drain_keyer();
    repeat (3) send_tick(1'b1, 1'b1);
    drain_keyer();
    set_config(ipk_pkg::MODE_B, 12'd3, 12'd4, 12'd1, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    drain_keyer();
    repeat (4) send_tick(1'b1, 1'b1);
    drain_keyer();
  endtask

  task automatic test_straight();
    set_config(ipk_pkg::MODE_STRAIGHT, pick_len(), pick_len(), pick_len(), 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    run_paddles(80);
    set_config(ipk_pkg::MODE_STRAIGHT, pick_len(), pick_len(), pick_len(), 1'b1);
    run_paddles(40);
  endtask

  task automatic test_mode_three();
    set_config(MODE_RSVD, pick_len(), pick_len(), pick_len(), 1'b1);
    run_paddles(120);
  endtask

  task automatic test_zero_lengths();
    set_config(ipk_pkg::MODE_B, '0, '0, '0, 1'b1);
    run_paddles(60);
    set_config(ipk_pkg::MODE_A, '0, '0, '0, 1'b0);
    run_paddles(60);
  endtask

  // Random lengths and modes; one phase runs without any idling
  task automatic test_iambic_random();
    for (int i = 0; i < 6; i++) begin
      set_config(i[0] ? ipk_pkg::MODE_B : ipk_pkg::MODE_A, pick_len(), pick_len(),
                 pick_len(), 1'($urandom_range(0, 1)));
      send_idle = (i != 2);
      sink_idle = (i != 2);
      run_paddles(70);
    end
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Hold off the output while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    set_config(ipk_pkg::MODE_B, 12'd2, 12'd4, 12'd1, 1'b1);
    send_idle = 1'b0;
    hold_req  = 1'b1;
    run_paddles(60);
    send_idle = 1'b1;
  endtask

  // Longer lengths: a squeeze with a long dit and gap, then a long dah tap
  task automatic test_long_lengths();
    set_config(ipk_pkg::MODE_A, 12'd20, 12'd1, 12'd20, 1'b1);
    repeat (2) send_tick(1'b1, 1'b1);
    drain_keyer();
    set_config(ipk_pkg::MODE_B, 12'd1, 12'd300, 12'd1, 1'b1);
    send_tick(1'b0, 1'b1);
    drain_keyer();
  endtask

  // Output ready: random stalls, plus one long hold on request
  initial begin : sink_proc
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
      end else if (sink_idle && $urandom_range(0, 99) < 20) begin
        out_if.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : line_check
    ipk_pkg::ipk_res_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (line_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result key %0b ptt %0b busy %0b", $time,
                 out_if.key_down, out_if.ptt_active, out_if.busy_res);
      end else begin
        want = line_q.pop_front();
        if (out_if.key_down !== want.key_down) begin
          err_cnt++;
          $display("%0t: key_down expected %0b actual %0b", $time,
                   want.key_down, out_if.key_down);
        end
        if (out_if.ptt_active !== want.ptt_active) begin
          err_cnt++;
          $display("%0t: ptt_active expected %0b actual %0b", $time,
                   want.ptt_active, out_if.ptt_active);
        end
        if (out_if.busy_res !== want.busy_res) begin
          err_cnt++;
          $display("%0t: busy_res expected %0b actual %0b", $time,
                   want.busy_res, out_if.busy_res);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no handshake
  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if (rst || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.dit_pressed <= 1'b0;
    in_if.dah_pressed <= 1'b0;

    // Model starts from the reset register values
    kcfg = '{key_mode_sel: ipk_pkg::MODE_RST, dot_ticks: ipk_pkg::DOT_RST,
             dash_ticks: ipk_pkg::DASH_RST, gap_ticks: ipk_pkg::GAP_RST,
             ptt_on: ipk_pkg::PTT_RST};
    kph     = ipk_pkg::PH_IDLE;
    lat_dit = 1'b0;
    lat_dah = 1'b0;
    dit_run = 1'b0;
    key_q   = 1'b0;
    ptt_q   = 1'b0;
    cnt     = '0;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_straight();
    test_mode_three();
    test_zero_lengths();
    test_iambic_random();
    test_backpressure();
    test_long_lengths();

    drain_keyer();
    wait_idle();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
